### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the histogram block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TMH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tmh assertion failed");

// Checked on every clock edge, reset included.
`define TMH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tmh assertion failed");

`endif

### design/tmh_pkg.sv
// ---------------------------------------------------------------------------
// tmh_pkg
// Widths, constants, tables and control structures of the histogram block.
// ---------------------------------------------------------------------------
`default_nettype none

package tmh_pkg;

  localparam int unsigned PT_BITS      = 20;
  localparam int unsigned ANGLE_BITS   = 16;
  localparam int unsigned MAX_BINS     = 128;
  localparam int unsigned BIN_BITS     = $clog2(MAX_BINS);
  localparam int unsigned MEV_BITS     = 22;
  localparam int unsigned CNT_BITS     = 32;
  localparam int unsigned NBIN_BITS    = 8;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned SQRT_STEPS   = 31;
  localparam int unsigned DIV_STEPS    = MEV_BITS;
  localparam int unsigned STEP_BITS    = 5;
  localparam int unsigned LEPTONS      = 4;
  localparam int unsigned LEP_BITS     = 2;
  localparam int unsigned IN_BITS      = LEPTONS * (PT_BITS + ANGLE_BITS);
  localparam int unsigned OUT_BITS     = 64;

  localparam logic [32:0] UNIT_START   = 33'd652032874;
  localparam logic [MEV_BITS-1:0] PT_OUT_MAX = {MEV_BITS{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_LOW_EDGE  = 2'd0;
  localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
  localparam logic [1:0] REG_BINS      = 2'd2;

  // Range codes of a result.
  localparam logic [1:0] RANGE_IN    = 2'd0;
  localparam logic [1:0] RANGE_UNDER = 2'd1;
  localparam logic [1:0] RANGE_OVER  = 2'd2;

  typedef struct packed {
    logic                 load;
    logic                 cinit;
    logic                 cstep;
    logic                 mulx;
    logic                 muly;
    logic                 accy;
    logic                 sqx;
    logic                 sqy;
    logic                 sinit;
    logic                 sstep;
    logic                 mag;
    logic                 dstep;
    logic                 rd;
    logic                 fin;
    logic [LEP_BITS-1:0]  lep;
    logic [STEP_BITS-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // Arctangent of 2^-i as a fraction of a full turn (2^32 is 2 pi).
  function automatic logic [31:0] atan_phase(input logic [STEP_BITS-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### design/tmh_ctrl.sv
// ---------------------------------------------------------------------------
// tmh_ctrl
// Sequencer that walks one event through the shared arithmetic units.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tmh_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  tmh_pkg::sts_t      sts_i,
  output tmh_pkg::cmd_t      cmd_o
);
  import tmh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CINIT, S_CSTEP, S_MULX, S_MULY, S_ACCY, S_SQX, S_SQY,
    S_SINIT, S_SQRT, S_MAG, S_DIV, S_READ, S_FIN
  } state_e;

  state_e               state_q;
  logic [STEP_BITS-1:0] cnt_q;
  logic [LEP_BITS-1:0]  lep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      lep_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CINIT;
            lep_q   <= '0;
          end
        end
        S_CINIT: begin
          state_q <= S_CSTEP;
          cnt_q   <= '0;
        end
        S_CSTEP: begin
          if (cnt_q == STEP_BITS'(CORDIC_STEPS - 1)) state_q <= S_MULX;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_MULX: state_q <= S_MULY;
        S_MULY: state_q <= S_ACCY;
        S_ACCY: begin
          if (lep_q == LEP_BITS'(LEPTONS - 1)) begin
            state_q <= S_SQX;
          end else begin
            lep_q   <= lep_q + 1'b1;
            state_q <= S_CINIT;
          end
        end
        S_SQX: state_q <= S_SQY;
        S_SQY: state_q <= S_SINIT;
        S_SINIT: begin
          state_q <= S_SQRT;
          cnt_q   <= '0;
        end
        S_SQRT: begin
          if (cnt_q == STEP_BITS'(SQRT_STEPS - 1)) state_q <= S_MAG;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_MAG: begin
          state_q <= S_DIV;
          cnt_q   <= '0;
        end
        S_DIV: begin
          if (cnt_q == STEP_BITS'(DIV_STEPS - 1)) state_q <= S_READ;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_READ: state_q <= S_FIN;
        S_FIN: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o       = '0;
    cmd_o.lep   = lep_q;
    cmd_o.step  = cnt_q;
    cmd_o.load  = in_ready_o && in_valid_i;
    cmd_o.cinit = (state_q == S_CINIT);
    cmd_o.cstep = (state_q == S_CSTEP);
    cmd_o.mulx  = (state_q == S_MULX);
    cmd_o.muly  = (state_q == S_MULY);
    cmd_o.accy  = (state_q == S_ACCY);
    cmd_o.sqx   = (state_q == S_SQX);
    cmd_o.sqy   = (state_q == S_SQY);
    cmd_o.sinit = (state_q == S_SINIT);
    cmd_o.sstep = (state_q == S_SQRT);
    cmd_o.mag   = (state_q == S_MAG);
    cmd_o.dstep = (state_q == S_DIV);
    cmd_o.rd    = (state_q == S_READ);
    cmd_o.fin   = (state_q == S_FIN) && sts_i.out_free;
  end

  `TMH_ASSERT(a_busy_after_load, cmd_o.load |=> !in_ready_o)
  `TMH_ASSERT(a_fin_needs_room, cmd_o.fin |-> sts_i.out_free)
  `TMH_ASSERT(a_cordic_count, cmd_o.cstep |-> (cnt_q < STEP_BITS'(CORDIC_STEPS)))
  `TMH_ASSERT(a_read_before_fin, $rose(state_q == S_FIN) |-> $past(cmd_o.rd))

endmodule

`default_nettype wire

### design/tmh_dp.sv
// ---------------------------------------------------------------------------
// tmh_dp
// CORDIC, products, square root, divider and the bin counter store.
// ---------------------------------------------------------------------------
`default_nettype none

module tmh_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  tmh_pkg::cmd_t                     cmd_i,
  output tmh_pkg::sts_t                     sts_o,
  input  wire logic [tmh_pkg::IN_BITS-1:0]  in_data_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [tmh_pkg::MEV_BITS-1:0] cfg_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [tmh_pkg::OUT_BITS-1:0]      out_data_o
);
  import tmh_pkg::*;

  // Configuration registers.
  logic [MEV_BITS-1:0]  low_q, width_q;
  logic [NBIN_BITS-1:0] bins_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= '0;
      width_q <= MEV_BITS'(2000);
      bins_q  <= NBIN_BITS'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_EDGE:  low_q   <= cfg_data_i;
        REG_BIN_WIDTH: width_q <= cfg_data_i;
        REG_BINS:      bins_q  <= cfg_data_i[NBIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Captured event.
  logic [PT_BITS-1:0]    pt_q  [LEPTONS];
  logic [ANGLE_BITS-1:0] ang_q [LEPTONS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < LEPTONS; k++) begin
        pt_q[k]  <= in_data_i[k*PT_BITS +: PT_BITS];
        ang_q[k] <= in_data_i[LEPTONS*PT_BITS + k*ANGLE_BITS +: ANGLE_BITS];
      end
    end
  end

  // CORDIC rotation, one step a cycle.
  logic signed [32:0] x_q, y_q;
  logic signed [33:0] z_q;
  logic               flip_q;
  logic [31:0]        phase;
  logic               flip;
  logic signed [32:0] xs, ys;
  logic signed [33:0] at;

  assign phase = {ang_q[cmd_i.lep], {(32-ANGLE_BITS){1'b0}}};
  assign flip  = phase[31] ^ phase[30];
  assign xs    = x_q >>> cmd_i.step;
  assign ys    = y_q >>> cmd_i.step;
  assign at    = signed'({2'b00, atan_phase(cmd_i.step)});

  always_ff @(posedge clk_i) begin
    if (cmd_i.cinit) begin
      x_q    <= UNIT_START;
      y_q    <= '0;
      z_q    <= signed'({{2{phase[31] ^ flip}}, phase[31] ^ flip, phase[30:0]});
      flip_q <= flip;
    end else if (cmd_i.cstep) begin
      if (!z_q[33]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  // Momentum components, one registered product a cycle.
  logic [51:0]        prod_q;
  logic               psign_q;
  logic signed [31:0] hx_q, hy_q;
  logic [31:0]        ax, ay;
  logic [29:0]        rnd;
  logic signed [31:0] part;

  assign ax   = x_q[32] ? 32'(-x_q) : x_q[31:0];
  assign ay   = y_q[32] ? 32'(-y_q) : y_q[31:0];
  assign rnd  = 30'((prod_q + 52'd2097152) >> 22);
  assign part = psign_q ? -signed'({2'b00, rnd}) : signed'({2'b00, rnd});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hx_q <= '0;
      hy_q <= '0;
    end
    if (cmd_i.mulx) begin
      prod_q  <= 52'(pt_q[cmd_i.lep]) * 52'(ax);
      psign_q <= x_q[32] ^ flip_q;
    end
    if (cmd_i.muly) begin
      hx_q    <= hx_q + part;
      prod_q  <= 52'(pt_q[cmd_i.lep]) * 52'(ay);
      psign_q <= y_q[32] ^ flip_q;
    end
    if (cmd_i.accy) hy_q <= hy_q + part;
  end

  // Squares and bit-serial square root.
  logic [31:0] ahx, ahy;
  logic [59:0] sq_q;
  logic [60:0] acc_q;
  logic [61:0] rad_q;
  logic [32:0] rem_q;
  logic [30:0] root_q;
  logic        sat_q;
  logic [34:0] rem2;
  logic [34:0] trial;

  assign ahx   = hx_q[31] ? 32'(-hx_q) : hx_q;
  assign ahy   = hy_q[31] ? 32'(-hy_q) : hy_q;
  assign rem2  = {rem_q, rad_q[61:60]};
  assign trial = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqx) begin
      sq_q  <= 60'(ahx[29:0]) * 60'(ahx[29:0]);
      sat_q <= (ahx[31:30] != 2'b00) || (ahy[31:30] != 2'b00);
    end
    if (cmd_i.sqy) begin
      acc_q <= 61'(sq_q);
      sq_q  <= 60'(ahy[29:0]) * 60'(ahy[29:0]);
    end
    if (cmd_i.sinit) begin
      rad_q  <= 62'(acc_q) + 62'(sq_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sstep) begin
      rad_q <= rad_q << 2;
      if (rem2 >= trial) begin
        rem_q  <= 33'(rem2 - trial);
        root_q <= {root_q[29:0], 1'b1};
      end else begin
        rem_q  <= rem2[32:0];
        root_q <= {root_q[29:0], 1'b0};
      end
    end
  end

  // Length, range check and restoring divider for the bin.
  logic [MEV_BITS-1:0] mag_q, dq_q, drem_q, wid;
  logic [23:0]         mlen;
  logic [MEV_BITS-1:0] mag;
  logic                under_q;
  logic [MEV_BITS:0]   dtrial;

  assign mlen   = 24'((32'(root_q) + 32'd128) >> 8);
  assign mag    = (sat_q || (mlen > 24'(PT_OUT_MAX))) ? PT_OUT_MAX : mlen[MEV_BITS-1:0];
  assign wid    = (width_q == '0) ? MEV_BITS'(1) : width_q;
  assign dtrial = {drem_q, dq_q[MEV_BITS-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag) begin
      mag_q   <= mag;
      under_q <= mag < low_q;
      dq_q    <= mag - low_q;
      drem_q  <= '0;
    end else if (cmd_i.dstep) begin
      if (dtrial >= {1'b0, wid}) begin
        drem_q <= MEV_BITS'(dtrial - {1'b0, wid});
        dq_q   <= {dq_q[MEV_BITS-2:0], 1'b1};
      end else begin
        drem_q <= dtrial[MEV_BITS-1:0];
        dq_q   <= {dq_q[MEV_BITS-2:0], 1'b0};
      end
    end
  end

  // Bin counter store with per-entry valid bits, underflow and overflow.
  logic [CNT_BITS-1:0] mem [MAX_BINS];
  logic [MAX_BINS-1:0] vld_q;
  logic [CNT_BITS-1:0] rd_q, uf_q, of_q;
  logic                rv_q, over_q;
  logic [BIN_BITS-1:0] idx_q;
  logic [NBIN_BITS-1:0] nbins;
  logic [CNT_BITS-1:0] cur, nc;
  logic                in_range;

  assign nbins    = (bins_q > NBIN_BITS'(MAX_BINS)) ? NBIN_BITS'(MAX_BINS) : bins_q;
  assign in_range = !under_q && !over_q;
  assign cur      = under_q ? uf_q : (over_q ? of_q : (rv_q ? rd_q : '0));
  assign nc       = (cur == {CNT_BITS{1'b1}}) ? cur : cur + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      over_q <= dq_q >= MEV_BITS'(nbins);
      idx_q  <= dq_q[BIN_BITS-1:0];
      rd_q   <= mem[dq_q[BIN_BITS-1:0]];
    end
    if (cmd_i.fin && in_range) mem[idx_q] <= nc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
      uf_q  <= '0;
      of_q  <= '0;
    end else begin
      if (cmd_i.rd) rv_q <= vld_q[dq_q[BIN_BITS-1:0]];
      if (cmd_i.fin) begin
        if (under_q) uf_q <= nc;
        else if (over_q) of_q <= nc;
        else vld_q[idx_q] <= 1'b1;
      end
    end
  end

  // Output register.
  logic                out_valid_q;
  logic [OUT_BITS-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_q <= {1'b0, nc,
                under_q ? RANGE_UNDER : (over_q ? RANGE_OVER : RANGE_IN),
                in_range ? idx_q : BIN_BITS'(0), mag_q};
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

### design/transverse_momentum_histogram_top.sv
// ---------------------------------------------------------------------------
// transverse_momentum_histogram_top
// Vector sum of four lepton momenta, its length, and a histogram of it.
// ---------------------------------------------------------------------------
// The slave stream takes one event per word: four transverse momenta and
// four azimuth angles. The block turns each angle into a cosine and sine with
// a shared CORDIC unit, scales by the momentum, sums the four vectors, takes
// the length with a bit-serial square root and finds the bin with a restoring
// divider. The master stream returns one word per event: the length, the
// bin, the range code and the new count of the counter that was bumped.
// The time from acceptance to the result word, and so between events, is
// set by the CORDIC unit (30 steps for each of the four leptons), the
// 31-step square root and the 22-step divider, all one step per cycle.
// s_axis_tready is high only while the sequencer is idle. The result sits in
// an output register, so a new event is accepted while the previous result
// still waits; if the receiver stalls, the next event holds in its last step
// until the register frees up. Reset clears the counters through per-bin
// valid bits at once, so no clearing pass is needed, and restores the
// default configuration. The user must write configuration only while
// idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module transverse_momentum_histogram_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // pt_a, pt_b, pt_c, pt_d, angle_a, angle_b, angle_c, angle_d
  input  wire logic [tmh_pkg::IN_BITS-1:0]   s_axis_tdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // system_pt_mev, bin_number, range_code, new_count, one zero pad bit
  output logic [tmh_pkg::OUT_BITS-1:0]       m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [tmh_pkg::MEV_BITS-1:0]  cfg_data_i
);
  import tmh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tmh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### verif/tmh_checker.sv
// ---------------------------------------------------------------------------
// tmh_checker
// Predicts every histogram result from the accepted event words and the
// register writes, and compares the returned result words field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tmh_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [tmh_pkg::IN_BITS-1:0]   s_axis_tdata,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tready,
  input  wire logic [tmh_pkg::OUT_BITS-1:0]  m_axis_tdata,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [tmh_pkg::MEV_BITS-1:0]  cfg_data_i,
  output int unsigned                        err_count_o,
  output int unsigned                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmh_pkg::*;

  typedef struct packed {
    logic [31:0] count;
    logic [1:0]  code;
    logic [6:0]  bin;
    logic [21:0] pt_mev;
  } hist_word_t;

  localparam longint ARCTAN[30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  logic [31:0] bin_tally [MAX_BINS];
  logic [31:0] under_tally, over_tally;
  logic [21:0] low_edge, bin_width;
  logic [7:0]  bin_limit;
  hist_word_t  expected_words [$];

  // Q30 cosine and sine of a 16-bit binary angle.
  function automatic void rotate_unit(input logic [15:0] ang, output longint c,
                                      output longint s);
    logic [31:0] phase;
    logic        flip;
    longint      x, y, z, nx;
    phase = {ang, 16'h0};
    flip  = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    if (flip) phase[31] = ~phase[31];
    z = longint'(signed'(phase));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint scale_q8(input logic [19:0] pt, input longint f);
    longint unsigned m, r;
    m = (f < 0) ? -f : f;
    r = (longint'(pt) * m + 64'd2097152) >> 22;
    return (f < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Sums the four lepton vectors, takes the length and books it.
  function automatic hist_word_t fill_histogram(input logic [IN_BITS-1:0] ev);
    longint hx, hy, c, s;
    longint unsigned mag, width, nbins, idx;
    hist_word_t w;
    hx = 0;
    hy = 0;
    for (int k = 0; k < 4; k++) begin
      rotate_unit(ev[80 + 16*k +: 16], c, s);
      hx += scale_q8(ev[20*k +: 20], c);
      hy += scale_q8(ev[20*k +: 20], s);
    end
    if (hx >= 64'sd1073741824 || hx <= -64'sd1073741824 ||
        hy >= 64'sd1073741824 || hy <= -64'sd1073741824) begin
      mag = 4194303;
    end else begin
      mag = (root_floor(hx*hx + hy*hy) + 128) >> 8;
      if (mag > 4194303) mag = 4194303;
    end
    width = (bin_width == 0) ? 1 : bin_width;
    nbins = (bin_limit > MAX_BINS) ? MAX_BINS : bin_limit;
    w = '0;
    w.pt_mev = mag[21:0];
    if (mag < low_edge) begin
      under_tally = sat_inc(under_tally);
      w.count = under_tally;
      w.code  = RANGE_UNDER;
    end else begin
      idx = (mag - low_edge) / width;
      if (idx >= nbins) begin
        over_tally = sat_inc(over_tally);
        w.count = over_tally;
        w.code  = RANGE_OVER;
      end else begin
        bin_tally[idx] = sat_inc(bin_tally[idx]);
        w.count = bin_tally[idx];
        w.bin   = idx[6:0];
        w.code  = RANGE_IN;
      end
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hist_word_t exp_w, got_w;
    if (!rst_ni) begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      under_tally = '0;
      over_tally  = '0;
      low_edge    = 22'd0;
      bin_width   = 22'd2000;
      bin_limit   = 8'd100;
      expected_words.delete();
      err_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOW_EDGE:  low_edge  = cfg_data_i;
          REG_BIN_WIDTH: bin_width = cfg_data_i;
          REG_BINS:      bin_limit = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_words.push_back(fill_histogram(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got_w = m_axis_tdata[62:0];
        if (expected_words.size() == 0) begin
          err_count_o++;
          if (err_count_o <= 10)
            $display("unexpected result word %h", m_axis_tdata);
        end else begin
          exp_w = expected_words.pop_front();
          if (got_w !== exp_w || m_axis_tdata[63] !== 1'b0) begin
            err_count_o++;
            if (err_count_o <= 10)
              $display("mismatch: pt %0d/%0d bin %0d/%0d code %0d/%0d count %0d/%0d",
                       exp_w.pt_mev, got_w.pt_mev, exp_w.bin, got_w.bin,
                       exp_w.code, got_w.code, exp_w.count, got_w.count);
          end
        end
      end
    end
    pending_o = expected_words.size();
  end

endmodule

`default_nettype wire

### verif/tb_transverse_momentum_histogram_top.sv
// ---------------------------------------------------------------------------
// tb_transverse_momentum_histogram_top
// Event stimulus and verdict for the transverse momentum histogram block.
// ---------------------------------------------------------------------------
// Directed events cover zero and full momenta, the angle extremes, the four
// quadrant edges and cancelling pairs. Random events follow under several
// register settings, including zero width, zero bins and bin counts above
// the maximum. A separate checker predicts and compares every result word.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_transverse_momentum_histogram_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tmh_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [IN_BITS-1:0]   s_axis_tdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OUT_BITS-1:0]  m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [1:0]           cfg_idx_i = '0;
  logic [MEV_BITS-1:0]  cfg_data_i = '0;
  int unsigned          err_count, pending;
  int unsigned          send_idle_pct = 38;
  int unsigned          recv_idle_pct = 81;
  int unsigned          cycle_count = 0;

  // The limit is many times the slowest correct run of the whole stimulus.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  transverse_momentum_histogram_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  tmh_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .err_count_o(err_count), .pending_o(pending)
  );

  // The receiver stalls at random at every falling edge.
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one event word after a random gap and holds it until accepted.
  // The valid is lowered after acceptance; the next call raises it again at
  // a later falling edge, so it is never assigned twice in one step.
  task automatic send_event(input logic [19:0] pt [4], input logic [15:0] ang [4]);
    logic [IN_BITS-1:0] w;
    for (int k = 0; k < 4; k++) begin
      w[20*k +: 20]      = pt[k];
      w[80 + 16*k +: 16] = ang[k];
    end
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tdata  = w;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Register writes happen only with nothing in flight. An accepted event
  // may still be in the sequencer after the last result, so wait out the
  // block's latency as well.
  task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
    while (pending != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_histogram(input logic [21:0] low, input logic [21:0] width,
                               input logic [21:0] nbins);
    write_reg(REG_LOW_EDGE, low);
    write_reg(REG_BIN_WIDTH, width);
    write_reg(REG_BINS, nbins);
  endtask

  // Random event: mostly moderate momenta so the bins fill, sometimes
  // the full field range so every bit toggles.
  task automatic random_event(input int unsigned pt_cap);
    logic [19:0] pt [4];
    logic [15:0] ang [4];
    for (int k = 0; k < 4; k++) begin
      pt[k]  = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(pt_cap));
      ang[k] = 16'($urandom);
    end
    send_event(pt, ang);
  endtask

  task automatic random_block(input int unsigned count, input int unsigned pt_cap);
    for (int n = 0; n < count; n++) begin
      // Pacing: one third each of slow receiver, slow sender, full speed.
      if (n < count / 3) begin
        send_idle_pct = 38; recv_idle_pct = 81;
      end else if (n < 2 * count / 3) begin
        send_idle_pct = 81; recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      random_event(pt_cap);
    end
  endtask

  initial begin
    logic [19:0] pt [4];
    logic [15:0] ang [4];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed events under the reset settings.
    pt = '{20'd0, 20'd0, 20'd0, 20'd0};
    ang = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    send_event(pt, ang);
    pt = '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF};
    send_event(pt, ang);                         // largest sum, all four aligned
    ang = '{16'h8000, 16'h7FFF, 16'h4000, 16'hC000};
    send_event(pt, ang);
    ang = '{16'h3FFF, 16'h4000, 16'hBFFF, 16'hC000};
    send_event(pt, ang);                         // quadrant edges
    pt = '{20'd50000, 20'd50000, 20'd30000, 20'd30000};
    ang = '{16'h0000, 16'h8000, 16'h2000, 16'hA000};
    send_event(pt, ang);                         // cancelling pairs
    pt = '{20'd1000, 20'd0, 20'd0, 20'd0};
    ang = '{16'h1234, 16'h0000, 16'h0000, 16'h0000};
    send_event(pt, ang);
    pt = '{20'd199999, 20'd0, 20'd0, 20'd0};
    send_event(pt, ang);                         // near the top bin edge
    pt = '{20'd200001, 20'd0, 20'd0, 20'd0};
    send_event(pt, ang);                         // just past it: overflow
    for (int n = 0; n < 8; n++) random_event(20000);
    random_block(220, 60000);

    // Zero width is one MeV; bin count above the maximum is clipped.
    set_histogram(22'd0, 22'd0, 22'h3FFFFF);
    pt = '{20'd60, 20'd0, 20'd0, 20'd0};
    ang = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    send_event(pt, ang);
    random_block(200, 150);

    // Extremes: top low edge and width, zero bins; index 3 is ignored.
    set_histogram(22'h3FFFFF, 22'h3FFFFF, 22'd0);
    write_reg(2'd3, 22'h155555);
    pt = '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF};
    send_event(pt, ang);
    random_block(150, 1000000);

    set_histogram(22'd0, 22'd1, 22'd0);
    random_block(100, 60000);

    set_histogram(22'd1000, 22'd1000, 22'd128);
    random_block(250, 60000);

    set_histogram(22'd50000, 22'd30000, 22'd1);
    random_block(150, 60000);

    set_histogram(22'd2000, 22'd700, 22'd129);
    random_block(220, 40000);

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
